[src/extent_map_address_translator_unit_defines.svh]
`ifndef EXTENT_MAP_ADDRESS_TRANSLATOR_UNIT_DEFINES_SVH
`define EXTENT_MAP_ADDRESS_TRANSLATOR_UNIT_DEFINES_SVH

// Checked outside reset.
`define EMAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define EMAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[src/emat_pkg.sv]
`default_nettype none

package emat_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int BLOCK_SHIFT = 12;
  localparam int TABLE_DEPTH = 64;
  localparam int TABLE_AW    = 6;
  localparam int BLK_W       = 32;
  localparam int BYTE_W      = 44;
  localparam int CNT_W       = 7;
  localparam int EXT_W       = (BLK_W + BLOCK_SHIFT > BYTE_W) ? BLK_W + BLOCK_SHIFT : BYTE_W;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_XLATE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMAPPED  = 2'd1,
    ST_TRUNCATED = 2'd2
  } chunk_status_e;

  typedef struct packed {
    req_e                req_type;
    logic [TABLE_AW-1:0] extent_slot;
    logic [BLK_W-1:0]    extent_logical_block;
    logic [BLK_W-1:0]    extent_physical_block;
    logic [BLK_W-1:0]    extent_block_count;
    logic [BYTE_W-1:0]   request_byte_offset;
    logic [BYTE_W-1:0]   request_byte_length;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] chunk_physical_offset;
    logic [BYTE_W-1:0] chunk_byte_length;
    logic              last_chunk;
    chunk_status_e     status;
  } rsp_t;

  typedef struct packed {
    logic [BLK_W-1:0] logical;
    logic [BLK_W-1:0] physical;
    logic [BLK_W-1:0] count;
  } extent_t;

  localparam int ENTRY_W = $bits(extent_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_EV,
    S_CALC,
    S_TAKE,
    S_CONT_RD,
    S_CONT_EV,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic load_wr;
    logic latch_req;
    logic ram_rd;
    logic idx_inc;
    logic srch_ld;
    logic calc_ld;
    logic cont_ld;
    logic take;
    logic trunc;
    logic mark_unmapped;
    logic flush;
  } ctl_t;

  typedef struct packed {
    logic req_xlate;
    logic n_zero;
    logic hit;
    logic len_zero;
    logic idx_last;
    logic take_last;
    logic hold_vld;
    logic take_ok;
  } sts_t;

  function automatic logic [EXT_W-1:0] to_bytes(input logic [BLK_W-1:0] blk);
    return EXT_W'(blk) << BLOCK_SHIFT;
  endfunction

endpackage

`default_nettype wire

[src/extent_map_address_translator_unit.sv]
// Extent map address translator.
// Input channel (in_valid_i/in_ready_o, in_data_i): a load transfer writes one
// extent entry (slot, logical block, physical block, block count) into the table;
// a translate transfer gives a byte offset and length and yields one or more
// chunks on the output channel (out_valid_o/out_ready_i, out_data_o).
// Config channel (cfg_valid_i/cfg_ready_o): extents_in_use, always ready; the user
// must write it only while the block is idle, which the block itself does not enforce.
// A translate walks the extent table through one RAM read port: the search
// reads and tests one entry after another until one covers the offset; the
// first chunk is then sized, each later chunk reads the next entry, and an
// empty extent is skipped. The walk covers n entries, n being extents_in_use
// capped at 64. A new transfer is taken once the previous translate has handed
// its last chunk to the output register.
// Each chunk waits one step in a holding register until the next chunk or the
// end of the table decides whether it is the last one.
// Reset clears the entry count and all valid flags; table contents stay
// undefined until loaded. When the receiver stalls, the output register holds
// its chunk, and a chunk that finds the holding register full waits for room.
`default_nettype none

module extent_map_address_translator_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire emat_pkg::req_t             in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output emat_pkg::rsp_t                  out_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [emat_pkg::CNT_W-1:0] cfg_data_i
);
  import emat_pkg::*;

  ctl_t ctl;
  sts_t st;

  assign cfg_ready_o = 1'b1;

  emat_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .st_i      (st),
    .ctl_o     (ctl)
  );

  emat_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .ctl_i      (ctl),
    .st_o       (st)
  );

endmodule

`default_nettype wire

[src/emat_ram.sv]
`default_nettype none

module emat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/emat_ctrl.sv]
`default_nettype none
`include "extent_map_address_translator_unit_defines.svh"

module emat_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire emat_pkg::sts_t st_i,
  output emat_pkg::ctl_t     ctl_o
);
  import emat_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (st_i.req_xlate) begin
            ctl_o.latch_req = 1'b1;
            if (st_i.n_zero) begin
              ctl_o.mark_unmapped = 1'b1;
              state_d             = S_FLUSH;
            end else begin
              state_d = S_SRCH_RD;
            end
          end else begin
            ctl_o.load_wr = 1'b1;
          end
        end
      end
      S_SRCH_RD: begin
        ctl_o.ram_rd = 1'b1;
        state_d      = S_SRCH_EV;
      end
      S_SRCH_EV: begin
        ctl_o.srch_ld = 1'b1;
        if (st_i.hit) begin
          state_d = S_CALC;
        end else if (st_i.idx_last) begin
          ctl_o.mark_unmapped = 1'b1;
          state_d             = S_FLUSH;
        end else begin
          ctl_o.idx_inc = 1'b1;
          state_d       = S_SRCH_RD;
        end
      end
      S_CALC: begin
        ctl_o.calc_ld = 1'b1;
        state_d       = S_TAKE;
      end
      S_TAKE: begin
        if (st_i.take_ok) begin
          ctl_o.take = 1'b1;
          if (st_i.take_last) begin
            state_d = S_FLUSH;
          end else if (st_i.idx_last) begin
            ctl_o.trunc = 1'b1;
            state_d     = S_FLUSH;
          end else begin
            ctl_o.idx_inc = 1'b1;
            state_d       = S_CONT_RD;
          end
        end
      end
      S_CONT_RD: begin
        ctl_o.ram_rd = 1'b1;
        state_d      = S_CONT_EV;
      end
      S_CONT_EV: begin
        if (st_i.len_zero) begin
          if (st_i.idx_last) begin
            ctl_o.trunc = 1'b1;
            state_d     = S_FLUSH;
          end else begin
            ctl_o.idx_inc = 1'b1;
            state_d       = S_CONT_RD;
          end
        end else begin
          ctl_o.cont_ld = 1'b1;
          state_d       = S_TAKE;
        end
      end
      S_FLUSH: begin
        ctl_o.flush = 1'b1;
        if (!st_i.hold_vld) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `EMAT_ASSERT(a_take_has_room, ctl_o.take |-> st_i.take_ok, "chunk taken with no room")
  `EMAT_ASSERT(a_flush_done, (state_q == S_FLUSH && !st_i.hold_vld) |=> state_q == S_IDLE,
               "flush did not return to idle")
  `EMAT_ASSERT_ALWAYS(a_idle_empty, state_q == S_IDLE |-> !st_i.hold_vld,
                      "pending chunk left behind in idle")

endmodule

`default_nettype wire

[src/emat_dp.sv]
`default_nettype none
`include "extent_map_address_translator_unit_defines.svh"

module emat_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire emat_pkg::req_t            in_data_i,
  output emat_pkg::rsp_t                 out_data_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  input  wire logic                      cfg_valid_i,
  input  wire logic [emat_pkg::CNT_W-1:0] cfg_data_i,
  input  wire emat_pkg::ctl_t            ctl_i,
  output emat_pkg::sts_t                 st_o
);
  import emat_pkg::*;

  logic [CNT_W-1:0]    cfg_q, n_eff;
  logic [TABLE_AW-1:0] idx_q, idx_d;
  logic [BYTE_W-1:0]   cur_q, rem_q, rem_d, phys_q, phys_d, take_len;
  logic [EXT_W-1:0]    pos_q, pos_d, len_q, len_d, ps_q, ps_d, avail_q, avail_d;
  rsp_t                hold_q, hold_d, out_q, out_d;
  logic                hold_vld_q, hold_vld_d, out_vld_q, out_vld_d;
  logic                out_free, move, take_lt, take_last;
  logic [EXT_W:0]      take_diff, ext_end;
  logic [EXT_W-1:0]    cur_x, rd_ls, rd_len;
  logic                slot_ok;
  extent_t             wr_ent, rd_ent;

  assign n_eff   = (cfg_q > CNT_W'(MAX_EXTENTS)) ? CNT_W'(MAX_EXTENTS) : cfg_q;
  assign slot_ok = {1'b0, in_data_i.extent_slot} < CNT_W'(MAX_EXTENTS);

  assign wr_ent.logical  = in_data_i.extent_logical_block;
  assign wr_ent.physical = in_data_i.extent_physical_block;
  assign wr_ent.count    = in_data_i.extent_block_count;

  emat_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ctl_i.load_wr && slot_ok),
    .waddr_i(in_data_i.extent_slot),
    .wdata_i(wr_ent),
    .re_i   (ctl_i.ram_rd),
    .raddr_i(idx_q),
    .rdata_o(rd_ent)
  );

  // cover test and chunk sizing
  assign cur_x   = EXT_W'(cur_q);
  assign rd_ls   = to_bytes(rd_ent.logical);
  assign rd_len  = to_bytes(rd_ent.count);
  assign ext_end = {1'b0, rd_ls} + {1'b0, rd_len};

  assign take_diff = {1'b0, EXT_W'(rem_q)} - {1'b0, avail_q};
  assign take_lt   = take_diff[EXT_W];
  assign take_last = take_lt || (take_diff[EXT_W-1:0] == '0);
  assign take_len  = take_lt ? rem_q : BYTE_W'(avail_q);

  assign out_free = !out_vld_q || out_ready_i;
  assign move     = hold_vld_q && out_free && (ctl_i.take || ctl_i.flush);

  always_comb begin
    st_o.req_xlate = (in_data_i.req_type == REQ_XLATE);
    st_o.n_zero    = (n_eff == '0);
    st_o.hit       = (cur_x >= rd_ls) && ({1'b0, cur_x} < ext_end);
    st_o.len_zero  = (rd_ent.count == '0);
    st_o.idx_last  = (CNT_W'(idx_q) + CNT_W'(1)) >= n_eff;
    st_o.take_last = take_last;
    st_o.hold_vld  = hold_vld_q;
    st_o.take_ok   = !hold_vld_q || out_free;
  end

  always_comb begin
    idx_d   = idx_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    len_d   = len_q;
    ps_d    = ps_q;
    avail_d = avail_q;
    phys_d  = phys_q;
    if (ctl_i.latch_req) begin
      idx_d = '0;
      rem_d = in_data_i.request_byte_length;
    end
    if (ctl_i.idx_inc) begin
      idx_d = idx_q + TABLE_AW'(1);
    end
    if (ctl_i.srch_ld) begin
      pos_d = cur_x - rd_ls;
      len_d = rd_len;
      ps_d  = to_bytes(rd_ent.physical);
    end
    if (ctl_i.calc_ld) begin
      avail_d = len_q - pos_q;
      phys_d  = BYTE_W'(ps_q + pos_q);
    end
    if (ctl_i.cont_ld) begin
      avail_d = rd_len;
      phys_d  = BYTE_W'(to_bytes(rd_ent.physical));
    end
    if (ctl_i.take) begin
      rem_d = take_lt ? '0 : BYTE_W'(take_diff);
    end
  end

  always_comb begin
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    if (move) begin
      out_d      = hold_q;
      out_vld_d  = 1'b1;
      hold_vld_d = 1'b0;
    end
    if (ctl_i.take) begin
      hold_d.chunk_physical_offset = phys_q;
      hold_d.chunk_byte_length     = take_len;
      hold_d.last_chunk            = take_last || ctl_i.trunc;
      hold_d.status                = (ctl_i.trunc && !take_last) ? ST_TRUNCATED : ST_OK;
      hold_vld_d                   = 1'b1;
    end else if (ctl_i.trunc) begin
      hold_d.last_chunk = 1'b1;
      hold_d.status     = ST_TRUNCATED;
    end
    if (ctl_i.mark_unmapped) begin
      hold_d.chunk_physical_offset = '0;
      hold_d.chunk_byte_length     = '0;
      hold_d.last_chunk            = 1'b1;
      hold_d.status                = ST_UNMAPPED;
      hold_vld_d                   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= '0;
      idx_q      <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      idx_q      <= idx_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_req) begin
      cur_q <= in_data_i.request_byte_offset;
    end
    rem_q   <= rem_d;
    pos_q   <= pos_d;
    len_q   <= len_d;
    ps_q    <= ps_d;
    avail_q <= avail_d;
    phys_q  <= phys_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_vld_q;

  `EMAT_ASSERT(a_trunc_has_chunk, (ctl_i.trunc && !ctl_i.take) |-> hold_vld_q,
               "truncation mark with no pending chunk")
  `EMAT_ASSERT(a_unmapped_empty, ctl_i.mark_unmapped |-> !hold_vld_q,
               "unmapped result over a pending chunk")
  `EMAT_ASSERT(a_take_no_overrun, ctl_i.take |-> (take_len <= rem_q),
               "chunk longer than what remains")

endmodule

`default_nettype wire

[tb/sv/extent_map_address_translator_unit_test.sv]
`timescale 1ns / 1ps

import emat_pkg::*;

class chunk_scoreboard;
  logic [BLK_W-1:0] ext_logical  [TABLE_DEPTH];
  logic [BLK_W-1:0] ext_physical [TABLE_DEPTH];
  logic [BLK_W-1:0] ext_count    [TABLE_DEPTH];
  logic [CNT_W-1:0] extents_in_use;
  rsp_t             expected_chunks [$];
  int               errors;
  int               chunks_checked;
  int               loads_seen;
  int               translations_seen;

  function new();
    extents_in_use    = '0;
    errors            = 0;
    chunks_checked    = 0;
    loads_seen        = 0;
    translations_seen = 0;
  endfunction

  function int search_depth();
    return (extents_in_use > MAX_EXTENTS) ? MAX_EXTENTS : int'(extents_in_use);
  endfunction

  function int pending();
    return expected_chunks.size();
  endfunction

  function void set_count(logic [CNT_W-1:0] value);
    extents_in_use = value;
  endfunction

  function void queue_chunk(rsp_t c);
    expected_chunks = {expected_chunks, c};
  endfunction

  // Called at each accepted input transfer.
  function void note_request(req_t r);
    int          n;
    int          hit;
    int          i;
    logic        done;
    logic [63:0] cur, remaining, ls, ps, len, pos, avail, take;
    rsp_t        c;
    rsp_t        walk [$];
    if (r.req_type == REQ_LOAD) begin
      loads_seen++;
      ext_logical[r.extent_slot]  = r.extent_logical_block;
      ext_physical[r.extent_slot] = r.extent_physical_block;
      ext_count[r.extent_slot]    = r.extent_block_count;
      return;
    end
    translations_seen++;
    n         = search_depth();
    cur       = 64'(r.request_byte_offset);
    remaining = 64'(r.request_byte_length);
    hit       = n;
    for (i = 0; i < n; i++) begin
      ls  = 64'(ext_logical[i]) << BLOCK_SHIFT;
      len = 64'(ext_count[i]) << BLOCK_SHIFT;
      if (cur >= ls && cur < ls + len) begin
        hit = i;
        break;
      end
    end
    if (hit == n) begin
      c.chunk_physical_offset = '0;
      c.chunk_byte_length     = '0;
      c.last_chunk            = 1'b1;
      c.status                = ST_UNMAPPED;
      queue_chunk(c);
      return;
    end
    done = 1'b0;
    for (i = hit; i < n && !done; i++) begin
      ls  = 64'(ext_logical[i]) << BLOCK_SHIFT;
      ps  = 64'(ext_physical[i]) << BLOCK_SHIFT;
      len = 64'(ext_count[i]) << BLOCK_SHIFT;
      pos = (i == hit) ? cur - ls : 64'd0;
      if (i == hit || len != 0) begin
        avail     = len - pos;
        take      = (remaining < avail) ? remaining : avail;
        remaining = remaining - take;
        c.chunk_physical_offset = BYTE_W'(ps + pos);
        c.chunk_byte_length     = BYTE_W'(take);
        c.last_chunk            = (remaining == 0);
        c.status                = ST_OK;
        walk = {walk, c};
        done = (remaining == 0);
      end
    end
    if (!done) begin
      walk[walk.size() - 1].last_chunk = 1'b1;
      walk[walk.size() - 1].status     = ST_TRUNCATED;
    end
    foreach (walk[k]) queue_chunk(walk[k]);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Called at each accepted output transfer.
  function void check_chunk(rsp_t got);
    rsp_t want;
    chunks_checked++;
    if (expected_chunks.size() == 0) begin
      errors++;
      $display("%0t: chunk expected none actual phys %0h len %0h last %0b status %0d",
               $time, got.chunk_physical_offset, got.chunk_byte_length, got.last_chunk,
               got.status);
      return;
    end
    want = expected_chunks.pop_front();
    compare_field("chunk_physical_offset", 64'(want.chunk_physical_offset),
                  64'(got.chunk_physical_offset));
    compare_field("chunk_byte_length", 64'(want.chunk_byte_length),
                  64'(got.chunk_byte_length));
    compare_field("last_chunk", 64'(want.last_chunk), 64'(got.last_chunk));
    compare_field("status", 64'(want.status), 64'(got.status));
  endfunction
endclass

module extent_map_address_translator_unit_test;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 300;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  req_t             in_data     = '0;
  logic             in_ready;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  rsp_t             out_data;
  logic             cfg_valid   = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data    = '0;
  logic             steady_flow = 1'b0;
  int               hold_ask    = 0;

  chunk_scoreboard sb = new();

  always #2 clk = ~clk;

  extent_map_address_translator_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Unused fields carry random bits; the block ignores them.
  function automatic req_t random_request(req_e kind);
    req_t r;
    r.req_type              = kind;
    r.extent_slot           = TABLE_AW'($urandom);
    r.extent_logical_block  = $urandom;
    r.extent_physical_block = $urandom;
    r.extent_block_count    = $urandom;
    r.request_byte_offset   = BYTE_W'(rand64());
    r.request_byte_length   = BYTE_W'(rand64());
    return r;
  endfunction

  // All tasks below start and end on a rising edge.
  task automatic send_request(input req_t item);
    while (!steady_flow && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_request(item);
  endtask

  task automatic load_entry(input int slot, input logic [BLK_W-1:0] lg,
                            input logic [BLK_W-1:0] ph, input logic [BLK_W-1:0] cnt);
    req_t r;
    r                       = random_request(REQ_LOAD);
    r.extent_slot           = TABLE_AW'(slot);
    r.extent_logical_block  = lg;
    r.extent_physical_block = ph;
    r.extent_block_count    = cnt;
    send_request(r);
  endtask

  task automatic send_translation(input logic [BYTE_W-1:0] offset,
                                  input logic [BYTE_W-1:0] length);
    req_t r;
    r                     = random_request(REQ_XLATE);
    r.request_byte_offset = offset;
    r.request_byte_length = length;
    send_request(r);
  endtask

  task automatic write_extent_count(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_count(value);
  endtask

  // Block idle: every chunk in, then room for a trailing load or walk.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Back-to-back extents with short runs and some empty ones.
  task automatic load_contiguous_table();
    logic [BLK_W-1:0] next_block;
    logic [BLK_W-1:0] cnt;
    next_block = ($urandom_range(3) == 0) ? 32'hFFFF_FF80 + $urandom_range(63)
                                          : $urandom_range(0, 1 << 20);
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      cnt = ($urandom_range(7) == 0) ? '0 : $urandom_range(1, 4);
      load_entry(s, next_block, $urandom, cnt);
      next_block = next_block + cnt;
    end
  endtask

  // Unrelated extents, some of them huge.
  task automatic load_scattered_table();
    for (int s = 0; s < TABLE_DEPTH; s++)
      load_entry(s, $urandom, $urandom, $urandom_range(1) ? $urandom : $urandom_range(0, 8));
  endtask

  // Mostly offsets inside a loaded extent with lengths reaching into later ones.
  function automatic req_t pick_translation();
    req_t        r;
    int          n, s, k;
    logic [63:0] ls, len, pos, span, length;
    r = random_request(REQ_XLATE);
    n = sb.search_depth();
    if (n == 0 || $urandom_range(99) < 12) return r;
    s = $urandom_range(n - 1);
    k = 0;
    while (k < n && sb.ext_count[s] == 0) begin
      s = (s + 1) % n;
      k++;
    end
    if (k == n) return r;
    ls  = 64'(sb.ext_logical[s]) << BLOCK_SHIFT;
    len = 64'(sb.ext_count[s]) << BLOCK_SHIFT;
    case ($urandom_range(9))
      0:       pos = 0;
      1:       pos = len - 1;
      default: pos = rand64() % len;
    endcase
    r.request_byte_offset = BYTE_W'(ls + pos);
    span = len - pos;
    k    = $urandom_range(6);
    for (int j = s + 1; j < n && j <= s + k; j++)
      span = span + (64'(sb.ext_count[j]) << BLOCK_SHIFT);
    case ($urandom_range(9))
      0:       length = 0;
      1:       length = span;
      2:       length = rand64();
      default: length = rand64() % (span + 1);
    endcase
    r.request_byte_length = BYTE_W'(length);
    return r;
  endfunction

  task automatic run_translations(input int count, input int hold_at);
    req_t r;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_ask <= hold_ask + 1;
      if ($urandom_range(19) == 0) begin
        r = random_request(REQ_LOAD);
        r.extent_block_count = $urandom_range(0, 6);
        send_request(r);
      end
      send_request(pick_translation());
    end
  endtask

  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_chunk(out_data);
      if (hold_left == 0 && hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady_flow || ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    req_t r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: everything unmapped
    write_extent_count(7'd0);
    send_translation('0, '0);
    r = '1;
    send_request(r);

    // small hand-built table: wrap, empty extent, huge top extent
    load_entry(0, 32'h0, 32'hFFFF_FFFF, 32'd2);
    load_entry(1, 32'h2, 32'h10, 32'd0);
    load_entry(2, 32'h2, 32'h100, 32'd3);
    load_entry(3, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    settle();
    write_extent_count(7'd4);
    send_translation(44'h0, 44'h0);
    send_translation(44'h1FFF, 44'h1);
    send_translation(44'h800, 44'h3000);
    send_translation(44'h0, 44'h5000);
    send_translation(44'h2000, 44'h10);
    send_translation(44'h5000, 44'h10);
    send_translation('1, '1);
    send_translation(44'h0, '1);
    settle();
    write_extent_count(7'd1);
    send_translation(44'h800, 44'h4000);
    send_translation(44'h2000, 44'h10);
    settle();

    load_contiguous_table();
    settle();
    write_extent_count(7'd64);
    run_translations(90, 40);
    settle();

    steady_flow <= 1'b1;
    write_extent_count(7'd127);
    run_translations(60, -1);
    settle();
    steady_flow <= 1'b0;

    load_scattered_table();
    settle();
    write_extent_count(CNT_W'($urandom_range(2, 63)));
    run_translations(60, -1);
    settle();

    load_contiguous_table();
    settle();
    write_extent_count(CNT_W'($urandom_range(1, 127)));
    run_translations(60, 25);
    settle();

    $display("Ran %0d loads and %0d translations, %0d chunks checked, %0d mismatches.",
             sb.loads_seen, sb.translations_seen, sb.chunks_checked, sb.errors);
    $display("Extent counts 0, 1, 4, 64, 127 and random; two long output stalls.");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
